/* rtl/deq_pkg.sv */
// deq_pkg: shared types and constants for the double-ended queue
// used by double_ended_queue; no dependencies
package deq_pkg;

  localparam int unsigned DEQ_CAPACITY = 1024;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned REQ_W        = 3;
  localparam int unsigned STATUS_W     = 2;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_PEEK_BACK  = 3'd4,
    REQ_PEEK_FRONT = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // request word
  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  // response word
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       entry_count;
  } rsp_t;

endpackage

/* rtl/deq_ram.sv */
// deq_ram: generic single-write, single-read ram with registered read data
// no dependencies
module deq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/double_ended_queue.sv */
// double_ended_queue: deque of signed 64-bit values in a circular ram
// depends on deq_pkg and deq_ram
//
// A request word (push back/front, pop back/front, peek back/front, clear) gives exactly
// one response word carrying a status, the value read and the entry count afterwards.
// Values sit in a CAPACITY-entry ram addressed by a head index and an occupancy count held
// in flip-flops. Each request is decoded in the cycle it is accepted: the pointers update
// at once and any ram access (one write for a push, one read for a pop or peek) is
// issued then. The ram registers the read data as the request enters a pending stage, and
// both are then moved to the output register. Sustained rate is one word per cycle while
// rsp_ready_i stays high. The ram needs no clearing pass after reset, since only held
// entries are ever read. A push onto a full deque returns a full error, a pop or peek on
// an empty one an empty error; neither changes the state.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned CAPACITY = DEQ_CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  logic req_valid_i,
  output logic req_ready_o,
  output rsp_t rsp_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] CapSum = SW'(CAPACITY);
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  // pointer state
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] occ_q, occ_d;

  // pending stage, waiting for ram read data
  logic                s1_v_q;
  logic                s1_rd_q, s1_rd_d;
  logic [STATUS_W-1:0] s1_status_q, s1_status_d;
  logic [COUNT_W-1:0]  s1_count_q;

  // output register
  logic rsp_v_q;
  rsp_t rsp_q;

  logic in_acc, s1_adv;
  logic is_full, is_empty;
  logic [SW-1:0] tail_sum, back_sum;
  logic [IW-1:0] tail_pos, back_pos, head_dec, head_inc;
  logic [IW:0]   head_plus;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // handshake
  assign s1_adv      = s1_v_q && (!rsp_v_q || rsp_ready_i);
  assign req_ready_o = !s1_v_q || s1_adv;
  assign in_acc      = req_valid_i && req_ready_o;

  // index arithmetic, wrapping by one compare and subtract
  assign is_full   = (occ_q == CapCnt);
  assign is_empty  = (occ_q == '0);
  assign tail_sum  = SW'(head_q) + SW'(occ_q);
  assign back_sum  = tail_sum - SW'(1);
  assign tail_pos  = (tail_sum >= CapSum) ? IW'(tail_sum - CapSum) : IW'(tail_sum);
  assign back_pos  = (back_sum >= CapSum) ? IW'(back_sum - CapSum) : IW'(back_sum);
  assign head_dec  = (head_q == '0) ? LastIdx : head_q - IW'(1);
  assign head_plus = {1'b0, head_q} + (IW+1)'(1);
  assign head_inc  = (head_plus >= (IW+1)'(CAPACITY)) ? '0 : head_plus[IW-1:0];

  // request decode
  always_comb begin
    head_d      = head_q;
    occ_d       = occ_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = tail_pos;
    ram_raddr   = head_q;
    s1_rd_d     = 1'b0;
    s1_status_d = ST_OK;
    if (in_acc) begin
      unique case (req_i.req_type) inside
        REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
          if (is_full) begin
            s1_status_d = ST_FULL;
          end else begin
            ram_we = 1'b1;
            occ_d  = occ_q + CW'(1);
            if (req_i.req_type == REQ_PUSH_FRONT) begin
              head_d    = head_dec;
              ram_waddr = head_dec;
            end
          end
        end
        REQ_POP_BACK, REQ_PEEK_BACK: begin
          if (is_empty) begin
            s1_status_d = ST_EMPTY;
          end else begin
            s1_status_d = ST_VALUE;
            s1_rd_d     = 1'b1;
            ram_re      = 1'b1;
            ram_raddr   = back_pos;
            if (req_i.req_type == REQ_POP_BACK) begin
              occ_d = occ_q - CW'(1);
            end
          end
        end
        REQ_POP_FRONT, REQ_PEEK_FRONT: begin
          if (is_empty) begin
            s1_status_d = ST_EMPTY;
          end else begin
            s1_status_d = ST_VALUE;
            s1_rd_d     = 1'b1;
            ram_re      = 1'b1;
            if (req_i.req_type == REQ_POP_FRONT) begin
              head_d = head_inc;
              occ_d  = occ_q - CW'(1);
            end
          end
        end
        REQ_CLEAR: begin
          head_d = '0;
          occ_d  = '0;
        end
        default: begin
          // unused code: report the count only
        end
      endcase
    end
  end

  // entry store
  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.push_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      occ_q   <= '0;
      s1_v_q  <= 1'b0;
      rsp_v_q <= 1'b0;
    end else begin
      head_q <= head_d;
      occ_q  <= occ_d;
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        rsp_v_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_rd_q     <= s1_rd_d;
      s1_status_q <= s1_status_d;
      s1_count_q  <= COUNT_W'(occ_d);
    end
    if (s1_adv) begin
      rsp_q.status      <= s1_status_q;
      rsp_q.read_value  <= s1_rd_q ? ram_rdata : '0;
      rsp_q.entry_count <= s1_count_q;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_v_q;

  // occupancy and head stay within the store
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CapCnt)
    else $error("occupancy beyond capacity");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, head_q} < (IW+1)'(CAPACITY))
    else $error("head index out of range");

  // no new read may overwrite read data still waiting in the pending stage
  a_no_read_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_adv) |-> !ram_re)
    else $error("ram read issued while pending data is stalled");

  // a refused push leaves the pointers alone
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_full && (req_i.req_type == REQ_PUSH_BACK ||
                           req_i.req_type == REQ_PUSH_FRONT))
    |=> ($stable(occ_q) && $stable(head_q)))
    else $error("push on a full deque changed state");

endmodule
